### sv/velocity_autocorrelation_core_assert.svh
// ----------------------------------------------------------------------------
// Velocity autocorrelation assertion macros
// Shared immediate-implication and next-cycle property forms.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_AUTOCORRELATION_CORE_ASSERT_SVH
`define VELOCITY_AUTOCORRELATION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vac assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vac assertion failed");

`endif

### sv/vac_pkg.sv
// ----------------------------------------------------------------------------
// Velocity autocorrelation package
// Shared types, constants and width helpers.
// ----------------------------------------------------------------------------
package vac_pkg;

    localparam int DEF_MAX_STEPS   = 64;
    localparam int DEF_MAX_ATOMS   = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int VEL_W     = 16;
    localparam int ACNT_W    = 7;
    localparam int LAG_W     = 6;
    localparam int CORR_W    = 16;
    localparam int QUO_W     = 17;
    localparam int DRAIN_LAT = 3;
    localparam int RAT_STEPS = 14;

    localparam logic signed [CORR_W-1:0] CORR_ONE = 16'sd16384;
    localparam logic [QUO_W-1:0] LIMIT_POS = 17'd32767;
    localparam logic [QUO_W-1:0] LIMIT_NEG = 17'd32768;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ACC,
        ST_DRAIN,
        ST_DINIT,
        ST_DIV,
        ST_MEAN,
        ST_RINIT,
        ST_RATIO,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MEAN,
        OP_RAT_INIT,
        OP_RAT_STEP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic wr_en;
        logic rd_en;
        logic m_zero;
    } t_dp_cmd;

    function automatic int acc_width(input int sample_bits, input int steps,
                                     input int atoms);
        return 2 * sample_bits + $clog2(3 * steps * atoms) + 1;
    endfunction

endpackage

### sv/vac_dp.sv
// ----------------------------------------------------------------------------
// Velocity autocorrelation datapath
// Vector store, dot-product accumulator, mean divider and ratio unit.
// ----------------------------------------------------------------------------
module vac_dp import vac_pkg::*; #(
    parameter int MAX_STEPS   = DEF_MAX_STEPS,
    parameter int MAX_ATOMS   = DEF_MAX_ATOMS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int SW  = $clog2(MAX_STEPS + 1),
    localparam int AIW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [SW-1:0]            i_wr_step,
    input  logic [AIW-1:0]           i_wr_atom,
    input  logic [VEL_W-1:0]         i_vel_x,
    input  logic [VEL_W-1:0]         i_vel_y,
    input  logic [VEL_W-1:0]         i_vel_z,
    input  logic [SW-1:0]            i_rd_step0,
    input  logic [SW-1:0]            i_rd_step1,
    input  logic [AIW-1:0]           i_rd_atom,
    input  logic [SW-1:0]            i_divisor,
    output logic signed [CORR_W-1:0] o_corr
);

    localparam int SB    = SAMPLE_BITS;
    localparam int DEPTH = MAX_STEPS * MAX_ATOMS;
    localparam int ADW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW    = acc_width(SAMPLE_BITS, MAX_STEPS, MAX_ATOMS);
    localparam int PW    = 2 * SB;

    logic [3*SB-1:0] mem [DEPTH];
    logic [SB-1:0]   s_x, s_y, s_z;

    if (SAMPLE_BITS <= VEL_W) begin : g_narrow
        assign s_x = i_vel_x[SB-1:0];
        assign s_y = i_vel_y[SB-1:0];
        assign s_z = i_vel_z[SB-1:0];
    end else begin : g_wide
        assign s_x = {{(SB-VEL_W){1'b0}}, i_vel_x};
        assign s_y = {{(SB-VEL_W){1'b0}}, i_vel_y};
        assign s_z = {{(SB-VEL_W){1'b0}}, i_vel_z};
    end

    logic [ADW-1:0] w_addr, r_addr0, r_addr1;
    assign w_addr  = ADW'(i_wr_step) * ADW'(MAX_ATOMS) + ADW'(i_wr_atom);
    assign r_addr0 = ADW'(i_rd_step0) * ADW'(MAX_ATOMS) + ADW'(i_rd_atom);
    assign r_addr1 = ADW'(i_rd_step1) * ADW'(MAX_ATOMS) + ADW'(i_rd_atom);

    logic [3*SB-1:0] r_rd0, r_rd1;
    logic            r_v1, r_v2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[w_addr] <= {s_z, s_y, s_x};
        end
        if (i_cmd.rd_en) begin
            r_rd0 <= mem[r_addr0];
            r_rd1 <= mem[r_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    logic signed [PW-1:0] r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        r_px <= $signed(r_rd0[SB-1:0]) * $signed(r_rd1[SB-1:0]);
        r_py <= $signed(r_rd0[2*SB-1:SB]) * $signed(r_rd1[2*SB-1:SB]);
        r_pz <= $signed(r_rd0[3*SB-1:2*SB]) * $signed(r_rd1[3*SB-1:2*SB]);
    end

    logic signed [AW-1:0] r_acc;
    logic [AW-1:0]        r_quo;
    logic [SW-1:0]        r_rem, r_den;
    logic                 r_neg;
    logic signed [AW-1:0] r_zl;
    logic [AW-1:0]        r_mag, r_r;
    logic                 r_mneg, r_sat;
    logic [QUO_W-1:0]     r_q;
    logic signed [CORR_W-1:0] r_corr;

    logic [SW:0]          div_t;
    logic                 div_ge;
    logic [AW-1:0]        zl_u;
    logic [AW:0]          two_r;
    logic                 two_r_ge;
    logic [QUO_W-1:0]     q_rnd, q_sat;
    logic signed [AW-1:0] mean_s;

    assign div_t    = {r_rem, r_quo[AW-1]};
    assign div_ge   = div_t >= {1'b0, r_den};
    assign zl_u     = r_zl;
    assign two_r    = {r_r, 1'b0};
    assign two_r_ge = two_r >= {1'b0, zl_u};
    assign mean_s   = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign q_rnd    = r_q + QUO_W'(two_r_ge);

    always_comb begin
        logic [QUO_W-1:0] lim;
        lim   = r_mneg ? LIMIT_NEG : LIMIT_POS;
        q_sat = (r_sat || (q_rnd > lim)) ? lim : q_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc <= r_acc + AW'(r_px) + AW'(r_py) + AW'(r_pz);
        end
        unique case (i_cmd.op)
            OP_CLEAR: begin
                r_acc <= '0;
            end
            OP_DIV_INIT: begin
                r_quo <= r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
                r_neg <= r_acc[AW-1];
                r_rem <= '0;
                r_den <= i_divisor;
            end
            OP_DIV_STEP: begin
                r_quo <= {r_quo[AW-2:0], div_ge};
                r_rem <= div_ge ? SW'(div_t - {1'b0, r_den}) : SW'(div_t);
            end
            OP_MEAN: begin
                r_mag  <= r_quo;
                r_mneg <= r_neg;
                if (i_cmd.m_zero) begin
                    r_zl <= mean_s;
                end
            end
            OP_RAT_INIT: begin
                r_sat <= {1'b0, r_mag} >= {zl_u, 1'b0};
                r_q   <= QUO_W'(r_mag >= zl_u);
                r_r   <= (r_mag >= zl_u) ? r_mag - zl_u : r_mag;
            end
            OP_RAT_STEP: begin
                r_q <= {r_q[QUO_W-2:0], two_r_ge};
                r_r <= two_r_ge ? AW'(two_r - {1'b0, zl_u}) : AW'(two_r);
            end
            OP_FINISH: begin
                if (i_cmd.m_zero) begin
                    r_corr <= CORR_ONE;
                end else if (r_zl[AW-1] || (r_zl == '0)) begin
                    r_corr <= '0;
                end else begin
                    r_corr <= r_mneg ? CORR_W'(-q_sat) : CORR_W'(q_sat);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_corr = r_corr;

endmodule

### sv/vac_ctrl.sv
// ----------------------------------------------------------------------------
// Velocity autocorrelation controller
// Load counters, lag and origin sequencing, and the iteration state machine.
// ----------------------------------------------------------------------------
`include "velocity_autocorrelation_core_assert.svh"

module vac_ctrl import vac_pkg::*; #(
    parameter int MAX_STEPS   = DEF_MAX_STEPS,
    parameter int MAX_ATOMS   = DEF_MAX_ATOMS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int SW  = $clog2(MAX_STEPS + 1),
    localparam int AIW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ACNT_W-1:0] i_cfg_wdata,
    input  logic              i_s_tvalid,
    input  logic              i_s_tlast,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output t_dp_cmd           o_cmd,
    output logic [SW-1:0]     o_wr_step,
    output logic [AIW-1:0]    o_wr_atom,
    output logic [SW-1:0]     o_rd_step0,
    output logic [SW-1:0]     o_rd_step1,
    output logic [AIW-1:0]    o_rd_atom,
    output logic [SW-1:0]     o_divisor,
    output logic [LAG_W-1:0]  o_lag,
    output logic              o_last
);

    localparam int AW   = acc_width(SAMPLE_BITS, MAX_STEPS, MAX_ATOMS);
    localparam int CW   = $clog2(MAX_ATOMS + 1);
    localparam int CMPW = (CW > ACNT_W) ? CW : ACNT_W;
    localparam int IW   = $clog2(AW + 1);

    t_state            r_state, n_state;
    logic [ACNT_W-1:0] r_ac;
    logic [SW-1:0]     r_step_total, n_step_total;
    logic [AIW-1:0]    r_pos, n_pos;
    logic [SW-1:0]     r_steps, n_steps;
    logic [SW-1:0]     r_m, n_m;
    logic [SW-1:0]     r_n, n_n;
    logic [AIW-1:0]    r_a, n_a;
    logic [IW-1:0]     r_it, n_it;

    logic [CW-1:0]     cnt;
    logic              last_lag;

    always_comb begin
        logic [CMPW-1:0] ac_e;
        ac_e = CMPW'(r_ac);
        if (ac_e == '0) begin
            cnt = CW'(1);
        end else if (ac_e > CMPW'(MAX_ATOMS)) begin
            cnt = CW'(MAX_ATOMS);
        end else begin
            cnt = CW'(ac_e);
        end
    end

    assign last_lag = (r_m + SW'(1)) == r_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac <= ACNT_W'(1);
        end else if (i_cfg_we) begin
            r_ac <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_step_total <= '0;
            r_pos        <= '0;
            r_steps      <= '0;
            r_m          <= '0;
            r_n          <= '0;
            r_a          <= '0;
            r_it         <= '0;
        end else begin
            r_state      <= n_state;
            r_step_total <= n_step_total;
            r_pos        <= n_pos;
            r_steps      <= n_steps;
            r_m          <= n_m;
            r_n          <= n_n;
            r_a          <= n_a;
            r_it         <= n_it;
        end
    end

    always_comb begin
        logic [CW-1:0] pos1;
        logic [SW:0]   tot;
        n_state      = r_state;
        n_step_total = r_step_total;
        n_pos        = r_pos;
        n_steps      = r_steps;
        n_m          = r_m;
        n_n          = r_n;
        n_a          = r_a;
        n_it         = r_it;
        o_cmd.op     = OP_NONE;
        o_cmd.wr_en  = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.m_zero = (r_m == '0);
        o_s_tready   = 1'b0;
        o_m_tvalid   = 1'b0;
        pos1         = CW'(r_pos) + CW'(1);
        tot          = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (r_step_total < SW'(MAX_STEPS)) begin
                        o_cmd.wr_en = 1'b1;
                        if (pos1 >= cnt) begin
                            n_pos        = '0;
                            n_step_total = r_step_total + SW'(1);
                        end else begin
                            n_pos = AIW'(pos1);
                        end
                    end
                    if (i_s_tlast) begin
                        tot = {1'b0, n_step_total} + (SW+1)'(n_pos != '0);
                        if (tot > (SW+1)'(MAX_STEPS)) begin
                            tot = (SW+1)'(MAX_STEPS);
                        end
                        n_steps      = SW'(tot);
                        n_step_total = '0;
                        n_pos        = '0;
                        n_m          = '0;
                        n_n          = '0;
                        n_a          = '0;
                        o_cmd.op     = OP_CLEAR;
                        n_state      = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                o_cmd.rd_en = 1'b1;
                if ((CW'(r_a) + CW'(1)) == cnt) begin
                    n_a = '0;
                    n_n = r_n + SW'(1);
                    if ((r_n + r_m + SW'(1)) == r_steps) begin
                        n_it    = '0;
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_a = r_a + AIW'(1);
                end
            end
            ST_DRAIN: begin
                n_it = r_it + IW'(1);
                if (r_it == IW'(DRAIN_LAT - 1)) begin
                    n_state = ST_DINIT;
                end
            end
            ST_DINIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_it     = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_it     = r_it + IW'(1);
                if (r_it == IW'(AW - 1)) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: begin
                o_cmd.op = OP_MEAN;
                n_state  = ST_RINIT;
            end
            ST_RINIT: begin
                o_cmd.op = OP_RAT_INIT;
                n_it     = '0;
                n_state  = ST_RATIO;
            end
            ST_RATIO: begin
                o_cmd.op = OP_RAT_STEP;
                n_it     = r_it + IW'(1);
                if (r_it == IW'(RAT_STEPS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                o_cmd.op = OP_FINISH;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    if (last_lag) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_m      = r_m + SW'(1);
                        n_n      = '0;
                        n_a      = '0;
                        o_cmd.op = OP_CLEAR;
                        n_state  = ST_ACC;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_wr_step  = r_step_total;
    assign o_wr_atom  = r_pos;
    assign o_rd_step0 = r_n + r_m;
    assign o_rd_step1 = r_n;
    assign o_rd_atom  = r_a;
    assign o_divisor  = r_steps - r_m;
    assign o_lag      = LAG_W'(r_m);
    assign o_last     = last_lag;

    `VAC_ASSERT_IMP(a_sides_exclusive, i_clk, i_rst_n, o_s_tready, !o_m_tvalid)
    `VAC_ASSERT_IMP(a_lag_in_range, i_clk, i_rst_n, r_state != ST_LOAD, r_m < r_steps)
    `VAC_ASSERT_NXT(a_final_starts, i_clk, i_rst_n, o_s_tready && i_s_tvalid && i_s_tlast,
                    r_state == ST_ACC && r_m == '0)
    `VAC_ASSERT_NXT(a_run_ends, i_clk, i_rst_n, o_m_tvalid && i_m_tready && last_lag,
                    r_state == ST_LOAD && r_step_total == '0)

endmodule

### sv/velocity_autocorrelation_core.sv
// ----------------------------------------------------------------------------
// Velocity autocorrelation core
// Normalized unbiased velocity autocorrelation over stored vector frames.
// ----------------------------------------------------------------------------
// Velocity words are taken one per cycle, time-major with atom_count atoms per
// step, into an internal store of MAX_STEPS*MAX_ATOMS vectors. The word with
// tlast high closes the run; the input then stalls while each lag m of the M
// loaded steps is computed and emitted with lag 0 first. The accumulator is
// AW = 2*SAMPLE_BITS + clog2(3*MAX_STEPS*MAX_ATOMS) + 1 bits wide (47 by
// default); one shared multiply-accumulate reads two store ports per cycle,
// and a bit-serial divider and ratio unit follow it. The store needs no
// clearing pass after reset. atom_count is clamped to 1..MAX_ATOMS.
module velocity_autocorrelation_core import vac_pkg::*; #(
    parameter int MAX_STEPS   = DEF_MAX_STEPS,
    parameter int MAX_ATOMS   = DEF_MAX_ATOMS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ACNT_W-1:0] i_cfg_wdata,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // vel_x [15:0], vel_y [31:16], vel_z [47:32]
    input  logic [47:0]       i_s_tdata,
    input  logic              i_s_tlast,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // lag [5:0], correlation [21:6], zero fill [23:22]
    output logic [23:0]       o_m_tdata,
    output logic              o_m_tlast
);

    localparam int SW  = $clog2(MAX_STEPS + 1);
    localparam int AIW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

    t_dp_cmd                  cmd;
    logic [SW-1:0]            wr_step, rd_step0, rd_step1, divisor;
    logic [AIW-1:0]           wr_atom, rd_atom;
    logic [LAG_W-1:0]         lag;
    logic signed [CORR_W-1:0] corr;

    vac_ctrl #(
        .MAX_STEPS   (MAX_STEPS),
        .MAX_ATOMS   (MAX_ATOMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tlast   (i_s_tlast),
        .o_s_tready  (o_s_tready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_cmd       (cmd),
        .o_wr_step   (wr_step),
        .o_wr_atom   (wr_atom),
        .o_rd_step0  (rd_step0),
        .o_rd_step1  (rd_step1),
        .o_rd_atom   (rd_atom),
        .o_divisor   (divisor),
        .o_lag       (lag),
        .o_last      (o_m_tlast)
    );

    vac_dp #(
        .MAX_STEPS   (MAX_STEPS),
        .MAX_ATOMS   (MAX_ATOMS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_wr_step  (wr_step),
        .i_wr_atom  (wr_atom),
        .i_vel_x    (i_s_tdata[15:0]),
        .i_vel_y    (i_s_tdata[31:16]),
        .i_vel_z    (i_s_tdata[47:32]),
        .i_rd_step0 (rd_step0),
        .i_rd_step1 (rd_step1),
        .i_rd_atom  (rd_atom),
        .i_divisor  (divisor),
        .o_corr     (corr)
    );

    assign o_m_tdata = {2'b00, corr, lag};

endmodule
